// File: sv/harmonic_mean_bitrate_selector_core_defines.svh
// Assertion macros used by the datapath file.
`ifndef HARMONIC_MEAN_BITRATE_SELECTOR_CORE_DEFINES_SVH
`define HARMONIC_MEAN_BITRATE_SELECTOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define HMBS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define HMBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/hmbs_pkg.sv
package hmbs_pkg;

    localparam int HISTORY_DEPTH   = 256;
    localparam int HIST_AW         = $clog2(HISTORY_DEPTH);
    localparam int CNT_W           = $clog2(HISTORY_DEPTH + 1);
    localparam int LADDER_DEPTH    = 16;
    localparam int LAD_AW          = $clog2(LADDER_DEPTH);
    localparam int WINDOW_MAX      = 32;
    localparam int N_W             = $clog2(WINDOW_MAX + 1);
    localparam int STARTUP_RECORDS = 5;
    localparam int DEFAULT_WINDOW  = 20;
    localparam int KBPS_W          = 32;
    localparam int HIST_W          = 3 * KBPS_W;
    localparam int GSUM_W          = KBPS_W + HIST_AW;
    localparam int RSUM_W          = KBPS_W + 1 + $clog2(WINDOW_MAX);
    localparam int DIV_W           = 64;
    localparam int DIV_CW          = $clog2(DIV_W);
    localparam int CHUNKS_W        = 5;
    localparam int WIN_W           = 6;
    localparam int QUAL_W          = 4;
    localparam int CFG_IW          = 2;
    localparam int CFG_DW          = 8;

    localparam logic [KBPS_W-1:0] KBPS_MAX  = '1;
    localparam logic [KBPS_W:0]   RECIP_ONE = {1'b1, {KBPS_W{1'b0}}};

    typedef enum logic [1:0] {
        DEC_HOLD    = 2'd0,
        DEC_UP      = 2'd1,
        DEC_DOWN    = 2'd2,
        DEC_STARTUP = 2'd3
    } decision_t;

    typedef enum logic [CFG_IW-1:0] {
        CFG_CHUNKS  = 2'd0,
        CFG_CHUNKED = 2'd1,
        CFG_WINDOW  = 2'd2,
        CFG_TOP     = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_RECORD = 1'b1
    } cmd_code_t;

    typedef enum logic [2:0] {
        DIV_NONE,
        DIV_KBPS,
        DIV_RECIP,
        DIV_MOD,
        DIV_MEAN
    } div_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_REC_CHK,
        ST_LAST_RD,
        ST_LAST_ACC,
        ST_LAST_KB,
        ST_LAST_KW,
        ST_MOD,
        ST_MOD_W,
        ST_WIN_CHK,
        ST_WIN_RD,
        ST_WIN_ACC,
        ST_WIN_KB,
        ST_WIN_KW,
        ST_WIN_RB,
        ST_WIN_RW,
        ST_MEAN,
        ST_MEAN_W,
        ST_DEC_RD0,
        ST_DEC_RD1,
        ST_DEC_FIN,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic    cap_in;
        logic    lad_wr;
        logic    rec_wr;
        logic    startup_load;
        logic    clr_walk;
        logic    gb_load_plain;
        logic    acc_last;
        div_op_t div_op;
        logic    last_set_max;
        logic    last_take;
        logic    win_init;
        logic    res_take;
        logic    win_acc;
        logic    kbps_set_max;
        logic    kbps_take;
        logic    recip_add_max;
        logic    recip_take;
        logic    mean_zero;
        logic    mean_take;
        logic    lad_sel_hi;
        logic    lad0_take;
        logic    result_calc;
        logic    out_load;
    } hmbs_cmd_t;

    typedef struct packed {
        logic is_rec;
        logic startup;
        logic chunked;
        logic last_more;
        logic gt_zero;
        logic div_done;
        logic win_more;
        logic rd_zero;
        logic close;
        logic kbps_zero;
        logic mean_skip;
        logic out_free;
    } hmbs_stat_t;

    function automatic logic [KBPS_W-1:0] sat_kbps(input logic [DIV_W-1:0] q);
        logic [KBPS_W-1:0] r;
        r = (q[DIV_W-1:KBPS_W] != '0) ? KBPS_MAX : q[KBPS_W-1:0];
        return r;
    endfunction

endpackage

// File: sv/hmbs_div.sv
module hmbs_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [hmbs_pkg::DIV_W-1:0] num,
    input  logic [hmbs_pkg::DIV_W-1:0] den,
    output logic                      busy,
    output logic                      done,
    output logic [hmbs_pkg::DIV_W-1:0] quo,
    output logic [hmbs_pkg::DIV_W-1:0] rem
);
    import hmbs_pkg::*;

    logic              busy_reg, done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_W-1:0]  quo_reg, rem_reg, den_reg;
    logic [DIV_W:0]    rem_sh, diff;

    // One quotient bit per cycle, restoring.
    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CW'(1);
                if (cnt_reg == DIV_CW'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_W])
            begin
                rem_reg <= diff[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// File: sv/hmbs_dp.sv
`include "harmonic_mean_bitrate_selector_core_defines.svh"

module hmbs_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hmbs_pkg::hmbs_cmd_t         cmd,
    output hmbs_pkg::hmbs_stat_t        stat,
    input  logic                        cfg_valid,
    input  logic [hmbs_pkg::CFG_IW-1:0] cfg_index,
    input  logic [hmbs_pkg::CFG_DW-1:0] cfg_data,
    input  logic                        command,
    input  logic [3:0]                  ladder_slot,
    input  logic [31:0]                 ladder_kbps,
    input  logic [31:0]                 bytes_received,
    input  logic [31:0]                 request_to_end_us,
    input  logic [31:0]                 start_to_end_us,
    input  logic [3:0]                  played_quality,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [3:0]                  next_quality,
    output logic [1:0]                  decision,
    output logic [31:0]                 mean_kbps,
    output logic [31:0]                 last_kbps
);
    import hmbs_pkg::*;

    // captured item
    logic              in_cmd_reg;
    logic [3:0]        in_slot_reg, in_pq_reg;
    logic [KBPS_W-1:0] in_kbps_reg, in_bytes_reg, in_req_reg, in_xfer_reg;

    // configuration
    logic [CHUNKS_W-1:0] chunks_reg;
    logic                chunked_reg;
    logic [WIN_W-1:0]    win_reg;
    logic [QUAL_W-1:0]   top_reg;

    logic [N_W-1:0]    win_eff;
    logic [QUAL_W-1:0] top_eff, cur;
    logic              chunked;

    // storage
    logic [HIST_W-1:0] hist_mem [HISTORY_DEPTH];
    logic [HIST_W-1:0] hist_rd_reg;
    logic [KBPS_W-1:0] lad_mem [LADDER_DEPTH];
    logic [KBPS_W-1:0] lad_rd_reg;
    logic [HIST_AW-1:0] wr_pos_reg, rd_addr;
    logic [LAD_AW-1:0]  lad_rd_addr;
    logic [KBPS_W-1:0]  seq_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [KBPS_W-1:0]  rd_bytes, rd_req, rd_xfer;

    // walk
    logic [CNT_W-1:0]    k_reg, k_inc;
    logic [N_W-1:0]      n_reg;
    logic [CHUNKS_W-1:0] res_reg;
    logic [GSUM_W-1:0]   gb_reg, gt_reg;
    logic [RSUM_W-1:0]   rsum_reg;
    logic [KBPS_W-1:0]   kbps_reg, last_reg, mean_reg, lad0_reg;
    logic [QUAL_W-1:0]   res_q_reg, dec_q;
    decision_t           res_dec_reg, dec_code;

    // output register
    logic              out_valid_reg;
    logic [QUAL_W-1:0] out_q_reg;
    decision_t         out_dec_reg;
    logic [KBPS_W-1:0] out_mean_reg, out_last_reg;

    // divider
    logic             div_start, div_busy, div_done;
    logic [DIV_W-1:0] div_num, div_den, div_q, div_r, gb_scaled;

    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            in_cmd_reg   <= command;
            in_slot_reg  <= ladder_slot;
            in_kbps_reg  <= ladder_kbps;
            in_bytes_reg <= bytes_received;
            in_req_reg   <= request_to_end_us;
            in_xfer_reg  <= start_to_end_us;
            in_pq_reg    <= played_quality;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunks_reg  <= '0;
            chunked_reg <= 1'b0;
            win_reg     <= WIN_W'(DEFAULT_WINDOW);
            top_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CHUNKS:  chunks_reg  <= cfg_data[CHUNKS_W-1:0];
                CFG_CHUNKED: chunked_reg <= cfg_data[0];
                CFG_WINDOW:  win_reg     <= cfg_data[WIN_W-1:0];
                CFG_TOP:     top_reg     <= cfg_data[QUAL_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        if (win_reg == '0)
            win_eff = N_W'(DEFAULT_WINDOW);
        else if (int'(win_reg) > WINDOW_MAX)
            win_eff = N_W'(WINDOW_MAX);
        else
            win_eff = N_W'(win_reg);
        top_eff = (int'(top_reg) > LADDER_DEPTH - 1) ? QUAL_W'(LADDER_DEPTH - 1) : top_reg;
        cur     = (in_pq_reg > top_eff) ? top_eff : in_pq_reg;
    end

    assign chunked = (chunks_reg != '0) && chunked_reg;

    // history ring, newest record sits just below the write position
    assign rd_addr  = wr_pos_reg - HIST_AW'(1) - k_reg[HIST_AW-1:0];
    assign rd_bytes = hist_rd_reg[HIST_W-1:2*KBPS_W];
    assign rd_req   = hist_rd_reg[2*KBPS_W-1:KBPS_W];
    assign rd_xfer  = hist_rd_reg[KBPS_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.rec_wr)
            hist_mem[wr_pos_reg] <= {in_bytes_reg, in_req_reg, in_xfer_reg};
        hist_rd_reg <= hist_mem[rd_addr];
    end

    assign lad_rd_addr = cmd.lad_sel_hi ? LAD_AW'(cur + QUAL_W'(1)) : LAD_AW'(cur);

    always_ff @(posedge clk)
    begin
        if (cmd.lad_wr && (int'(in_slot_reg) < LADDER_DEPTH))
            lad_mem[LAD_AW'(in_slot_reg)] <= in_kbps_reg;
        lad_rd_reg <= lad_mem[lad_rd_addr];
    end

    assign k_inc = k_reg + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos_reg    <= '0;
            seq_reg       <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rec_wr)
            begin
                wr_pos_reg <= wr_pos_reg + HIST_AW'(1);
                seq_reg    <= seq_reg + KBPS_W'(1);
                if (cnt_reg != CNT_W'(HISTORY_DEPTH))
                    cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.clr_walk || cmd.win_init)
                k_reg <= '0;
            else if (cmd.acc_last || cmd.win_acc)
                k_reg <= k_inc;
            if (cmd.win_init)
                n_reg <= '0;
            else if (cmd.recip_add_max || cmd.recip_take)
                n_reg <= n_reg + N_W'(1);
            // residue of the record's sequence number, counted down per step
            if (cmd.res_take)
                res_reg <= div_r[CHUNKS_W-1:0];
            else if (cmd.win_acc)
                res_reg <= (res_reg == '0) ? chunks_reg - CHUNKS_W'(1) : res_reg - CHUNKS_W'(1);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        dec_q    = cur;
        dec_code = DEC_HOLD;
        if ((cur != '0) && (lad0_reg > last_reg))
        begin
            dec_q    = cur - QUAL_W'(1);
            dec_code = DEC_DOWN;
        end
        else if ((cur < top_eff) && (lad_rd_reg < mean_reg))
        begin
            if (!(lad_rd_reg > last_reg))
            begin
                dec_q    = cur + QUAL_W'(1);
                dec_code = DEC_UP;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_walk || cmd.win_init || cmd.recip_add_max || cmd.recip_take)
        begin
            gb_reg <= '0;
            gt_reg <= '0;
        end
        else if (cmd.gb_load_plain)
        begin
            gb_reg <= GSUM_W'(in_bytes_reg);
            gt_reg <= GSUM_W'(in_req_reg);
        end
        else if (cmd.acc_last)
        begin
            gb_reg <= gb_reg + GSUM_W'(rd_bytes);
            gt_reg <= gt_reg + GSUM_W'(rd_xfer);
        end
        else if (cmd.win_acc && (rd_bytes != '0))
        begin
            if (chunked)
            begin
                gb_reg <= gb_reg + GSUM_W'(rd_bytes);
                gt_reg <= gt_reg + GSUM_W'(rd_req);
            end
            else
            begin
                gb_reg <= GSUM_W'(rd_bytes);
                gt_reg <= GSUM_W'(rd_req);
            end
        end

        if (cmd.win_init)
            rsum_reg <= '0;
        else if (cmd.recip_add_max)
            rsum_reg <= rsum_reg + RSUM_W'(RECIP_ONE);
        else if (cmd.recip_take)
            rsum_reg <= rsum_reg + RSUM_W'(div_q[KBPS_W:0]);

        if (cmd.kbps_set_max)
            kbps_reg <= KBPS_MAX;
        else if (cmd.kbps_take)
            kbps_reg <= sat_kbps(div_q);

        if (cmd.startup_load)
            last_reg <= '0;
        else if (cmd.last_set_max)
            last_reg <= KBPS_MAX;
        else if (cmd.last_take)
            last_reg <= sat_kbps(div_q);

        if (cmd.startup_load || cmd.mean_zero)
            mean_reg <= '0;
        else if (cmd.mean_take)
            mean_reg <= sat_kbps(div_q);

        if (cmd.lad0_take)
            lad0_reg <= lad_rd_reg;

        if (cmd.startup_load)
        begin
            res_q_reg   <= '0;
            res_dec_reg <= DEC_STARTUP;
        end
        else if (cmd.result_calc)
        begin
            res_q_reg   <= dec_q;
            res_dec_reg <= dec_code;
        end

        if (cmd.out_load)
        begin
            out_q_reg    <= res_q_reg;
            out_dec_reg  <= res_dec_reg;
            out_mean_reg <= mean_reg;
            out_last_reg <= last_reg;
        end
    end

    // bytes * 8000 as shifts: 8000 = 8192 - 128 - 64
    assign gb_scaled = (DIV_W'(gb_reg) << 13) - (DIV_W'(gb_reg) << 7) - (DIV_W'(gb_reg) << 6);

    always_comb
    begin
        case (cmd.div_op)
            DIV_KBPS:
            begin
                div_num = gb_scaled;
                div_den = DIV_W'(gt_reg);
            end
            DIV_RECIP:
            begin
                div_num = DIV_W'(RECIP_ONE);
                div_den = DIV_W'(kbps_reg);
            end
            DIV_MOD:
            begin
                div_num = DIV_W'(seq_reg - KBPS_W'(1));
                div_den = DIV_W'(chunks_reg);
            end
            DIV_MEAN:
            begin
                div_num = DIV_W'({n_reg, {KBPS_W{1'b0}}});
                div_den = DIV_W'(rsum_reg);
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    assign div_start = (cmd.div_op != DIV_NONE);

    hmbs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_q),
        .rem   (div_r)
    );

    always_comb
    begin
        stat.is_rec    = (in_cmd_reg == CMD_RECORD);
        stat.startup   = (cnt_reg < CNT_W'(STARTUP_RECORDS));
        stat.chunked   = chunked;
        stat.last_more = (k_inc < cnt_reg) && (k_inc <= CNT_W'(chunks_reg));
        stat.gt_zero   = (gt_reg == '0);
        stat.div_done  = div_done;
        stat.win_more  = (k_reg < cnt_reg) && (n_reg < win_eff);
        stat.rd_zero   = (rd_bytes == '0);
        stat.close     = !chunked || (res_reg == '0);
        stat.kbps_zero = (kbps_reg == '0);
        stat.mean_skip = (n_reg == '0) || (rsum_reg == '0);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign next_quality = out_q_reg;
    assign decision     = out_dec_reg;
    assign mean_kbps    = out_mean_reg;
    assign last_kbps    = out_last_reg;

    `HMBS_ASSERT_IMPLY(a_div_start_idle, clk, rst_n, div_start, !div_busy, "divider restarted while busy")
    `HMBS_ASSERT_IMPLY(a_walk_in_history, clk, rst_n, 1'b1, k_reg <= cnt_reg, "walk ran past stored records")
    `HMBS_ASSERT_IMPLY(a_samples_bound, clk, rst_n, 1'b1, n_reg <= N_W'(WINDOW_MAX), "sample count above window limit")
    `HMBS_ASSERT_NEXT(a_quality_bound, clk, rst_n, cmd.out_load, next_quality <= top_eff, "chosen quality above ladder top")
    `HMBS_ASSERT_NEXT(a_startup_zero, clk, rst_n, cmd.out_load && (res_dec_reg == DEC_STARTUP), (mean_kbps == '0) && (last_kbps == '0), "startup result carries estimates")

endmodule

// File: sv/hmbs_ctrl.sv
module hmbs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hmbs_pkg::hmbs_stat_t stat,
    output hmbs_pkg::hmbs_cmd_t  cmd
);
    import hmbs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_op = DIV_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.cap_in = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.is_rec)
                begin
                    cmd.rec_wr = 1'b1;
                    state_next = ST_REC_CHK;
                end
                else
                begin
                    cmd.lad_wr = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_REC_CHK:
            begin
                if (stat.startup)
                begin
                    cmd.startup_load = 1'b1;
                    state_next       = ST_PUSH;
                end
                else if (stat.chunked)
                begin
                    cmd.clr_walk = 1'b1;
                    state_next   = ST_LAST_RD;
                end
                else
                begin
                    cmd.gb_load_plain = 1'b1;
                    state_next        = ST_LAST_KB;
                end
            end
            ST_LAST_RD:
                state_next = ST_LAST_ACC;
            ST_LAST_ACC:
            begin
                cmd.acc_last = 1'b1;
                state_next   = stat.last_more ? ST_LAST_RD : ST_LAST_KB;
            end
            ST_LAST_KB:
            begin
                if (stat.gt_zero)
                begin
                    cmd.last_set_max = 1'b1;
                    cmd.win_init     = 1'b1;
                    state_next       = stat.chunked ? ST_MOD : ST_WIN_CHK;
                end
                else
                begin
                    cmd.div_op = DIV_KBPS;
                    state_next = ST_LAST_KW;
                end
            end
            ST_LAST_KW:
            begin
                if (stat.div_done)
                begin
                    cmd.last_take = 1'b1;
                    cmd.win_init  = 1'b1;
                    state_next    = stat.chunked ? ST_MOD : ST_WIN_CHK;
                end
            end
            ST_MOD:
            begin
                cmd.div_op = DIV_MOD;
                state_next = ST_MOD_W;
            end
            ST_MOD_W:
            begin
                if (stat.div_done)
                begin
                    cmd.res_take = 1'b1;
                    state_next   = ST_WIN_CHK;
                end
            end
            ST_WIN_CHK:
                state_next = stat.win_more ? ST_WIN_RD : ST_MEAN;
            ST_WIN_RD:
                state_next = ST_WIN_ACC;
            ST_WIN_ACC:
            begin
                cmd.win_acc = 1'b1;
                if (stat.rd_zero || !stat.close)
                    state_next = ST_WIN_CHK;
                else
                    state_next = ST_WIN_KB;
            end
            ST_WIN_KB:
            begin
                if (stat.gt_zero)
                begin
                    cmd.kbps_set_max = 1'b1;
                    state_next       = ST_WIN_RB;
                end
                else
                begin
                    cmd.div_op = DIV_KBPS;
                    state_next = ST_WIN_KW;
                end
            end
            ST_WIN_KW:
            begin
                if (stat.div_done)
                begin
                    cmd.kbps_take = 1'b1;
                    state_next    = ST_WIN_RB;
                end
            end
            ST_WIN_RB:
            begin
                if (stat.kbps_zero)
                begin
                    cmd.recip_add_max = 1'b1;
                    state_next        = ST_WIN_CHK;
                end
                else
                begin
                    cmd.div_op = DIV_RECIP;
                    state_next = ST_WIN_RW;
                end
            end
            ST_WIN_RW:
            begin
                if (stat.div_done)
                begin
                    cmd.recip_take = 1'b1;
                    state_next     = ST_WIN_CHK;
                end
            end
            ST_MEAN:
            begin
                if (stat.mean_skip)
                begin
                    cmd.mean_zero = 1'b1;
                    state_next    = ST_DEC_RD0;
                end
                else
                begin
                    cmd.div_op = DIV_MEAN;
                    state_next = ST_MEAN_W;
                end
            end
            ST_MEAN_W:
            begin
                if (stat.div_done)
                begin
                    cmd.mean_take = 1'b1;
                    state_next    = ST_DEC_RD0;
                end
            end
            ST_DEC_RD0:
                state_next = ST_DEC_RD1;
            ST_DEC_RD1:
            begin
                cmd.lad0_take  = 1'b1;
                cmd.lad_sel_hi = 1'b1;
                state_next     = ST_DEC_FIN;
            end
            ST_DEC_FIN:
            begin
                cmd.result_calc = 1'b1;
                state_next      = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// File: sv/harmonic_mean_bitrate_selector_core.sv
// Channel   Handshake             Payload
// in        in_valid / in_ready   command, ladder_slot, ladder_kbps, bytes_received,
//                                 request_to_end_us, start_to_end_us, played_quality
// out       out_valid / out_ready next_quality, decision, mean_kbps, last_kbps
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// A startup record skips the estimates. Every division runs on the shared 64-step
// restoring divider. A steady-state record computes the last estimate (summing the
// newest records in chunked mode, then a group phase division), walks the history
// newest first with a rate and a reciprocal division per window sample, and then
// takes the mean and the decision.
// Reset (rst_n low, asynchronous) clears control state; ladder and history contents
// stay unknown until written. A waiting result does not block the next transaction
// from being taken; only the finished next result stalls until the output frees up.
module harmonic_mean_bitrate_selector_core (
    input  logic                        clk,
    input  logic                        rst_n,
    // input transactions
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        command,
    input  logic [3:0]                  ladder_slot,
    input  logic [31:0]                 ladder_kbps,
    input  logic [31:0]                 bytes_received,
    input  logic [31:0]                 request_to_end_us,
    input  logic [31:0]                 start_to_end_us,
    input  logic [3:0]                  played_quality,
    // result transactions
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [3:0]                  next_quality,
    output logic [1:0]                  decision,
    output logic [31:0]                 mean_kbps,
    output logic [31:0]                 last_kbps,
    // register writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [hmbs_pkg::CFG_IW-1:0] cfg_index,
    input  logic [hmbs_pkg::CFG_DW-1:0] cfg_data
);
    import hmbs_pkg::*;

    hmbs_cmd_t  cmd;
    hmbs_stat_t stat;

    // Always writable; software must write the registers only while idle (unenforced).
    assign cfg_ready = 1'b1;

    // Sequence the walk: dispatch, last estimate, window walk, mean, decide, push.
    hmbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold history ring, ladder, accumulators, divider and output register.
    hmbs_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .command           (command),
        .ladder_slot       (ladder_slot),
        .ladder_kbps       (ladder_kbps),
        .bytes_received    (bytes_received),
        .request_to_end_us (request_to_end_us),
        .start_to_end_us   (start_to_end_us),
        .played_quality    (played_quality),
        .out_ready         (out_ready),
        .out_valid         (out_valid),
        .next_quality      (next_quality),
        .decision          (decision),
        .mean_kbps         (mean_kbps),
        .last_kbps         (last_kbps)
    );

endmodule

// File: tb/tb_harmonic_mean_bitrate_selector_core.sv
`timescale 1ns / 1ps

module tb_harmonic_mean_bitrate_selector_core;
    import hmbs_pkg::*;

    // Limit on the whole run in clock cycles.
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        cmd_code_t   cmd;
        logic [3:0]  slot;
        logic [31:0] kbps;
        logic [31:0] bytes;
        logic [31:0] req_us;
        logic [31:0] xfer_us;
        logic [3:0]  played;
    } dl_item_t;

    typedef struct {
        logic [3:0]  quality;
        decision_t   dec;
        logic [31:0] mean;
        logic [31:0] last;
    } pick_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [3:0]  ladder_slot;
    logic [31:0] ladder_kbps;
    logic [31:0] bytes_received;
    logic [31:0] request_to_end_us;
    logic [31:0] start_to_end_us;
    logic [3:0]  played_quality;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  next_quality;
    logic [1:0]  decision;
    logic [31:0] mean_kbps;
    logic [31:0] last_kbps;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;

    harmonic_mean_bitrate_selector_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .command           (command),
        .ladder_slot       (ladder_slot),
        .ladder_kbps       (ladder_kbps),
        .bytes_received    (bytes_received),
        .request_to_end_us (request_to_end_us),
        .start_to_end_us   (start_to_end_us),
        .played_quality    (played_quality),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .next_quality      (next_quality),
        .decision          (decision),
        .mean_kbps         (mean_kbps),
        .last_kbps         (last_kbps),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // Shadow copy of the selector: history ring, ladder and registers.
    logic [31:0] hist_bytes [HISTORY_DEPTH];
    logic [31:0] hist_req   [HISTORY_DEPTH];
    logic [31:0] hist_xfer  [HISTORY_DEPTH];
    logic [31:0] ladder     [LADDER_DEPTH];
    logic [7:0]  hist_wpos;
    int unsigned rec_total;
    int unsigned rec_seq;
    logic [4:0]  reg_chunks;
    logic        reg_chunked;
    logic [5:0]  reg_window;
    logic [3:0]  reg_top;

    dl_item_t pending_items[$];
    pick_t    pick_q[$];

    int  mismatches;
    int  picks_seen;
    bit  in_taken;
    bit  out_taken;
    bit  cfg_taken;
    bit  long_hold;
    int  send_gap;
    int  recv_wait;
    bit  send_burst;
    int  cycles;

    // Throughput in kbit/s from bytes and microseconds, saturated; zero time saturates.
    function automatic logic [63:0] tput_kbps(input logic [63:0] b, input logic [63:0] us);
        logic [63:0] q;
        if (us == 0)
            return 64'hFFFF_FFFF;
        q = (b * 64'd8000) / us;
        return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
    endfunction

    // Q32 reciprocal of a rate; a zero rate gives 2^32.
    function automatic logic [63:0] tput_recip(input logic [63:0] k);
        if (k == 0)
            return 64'h1_0000_0000;
        return 64'h1_0000_0000 / k;
    endfunction

    // Apply one transaction to the shadow state and work out the quality pick it causes.
    function automatic void select_quality(input dl_item_t it, output bit got, output pick_t r);
        int unsigned avail, win, n, cur, top, k, abs_idx;
        logic [7:0]  p;
        logic [63:0] b, t, gb, gt, rsum, last, mean;
        bit          grouped;
        got = 0;
        r = '{4'd0, DEC_STARTUP, 32'd0, 32'd0};
        if (it.cmd == CMD_LOAD) begin
            ladder[it.slot] = it.kbps;
            return;
        end
        hist_bytes[hist_wpos] = it.bytes;
        hist_req[hist_wpos]   = it.req_us;
        hist_xfer[hist_wpos]  = it.xfer_us;
        hist_wpos = hist_wpos + 8'd1;
        rec_seq = rec_seq + 1;
        if (rec_total != 32'hFFFF_FFFF)
            rec_total = rec_total + 1;
        got = 1;
        if (rec_total < STARTUP_RECORDS)
            return;

        avail = (rec_total < HISTORY_DEPTH) ? rec_total : HISTORY_DEPTH;
        grouped = (reg_chunks != 0) && reg_chunked;
        if (grouped) begin
            b = 0;
            t = 0;
            for (k = 0; k < avail && k <= reg_chunks; k++) begin
                p = hist_wpos - 8'd1 - k[7:0];
                b += hist_bytes[p];
                t += hist_xfer[p];
            end
            last = tput_kbps(b, t);
        end else begin
            p = hist_wpos - 8'd1;
            last = tput_kbps(hist_bytes[p], hist_req[p]);
        end

        win = (reg_window == 0) ? DEFAULT_WINDOW : reg_window;
        if (win > WINDOW_MAX)
            win = WINDOW_MAX;
        n = 0;
        rsum = 0;
        gb = 0;
        gt = 0;
        // Walk newest first, skip empty records; in chunked mode close a group on
        // each segment boundary and drop the open group left at the end.
        for (k = 0; k < avail && n < win; k++) begin
            p = hist_wpos - 8'd1 - k[7:0];
            if (hist_bytes[p] == 0)
                continue;
            if (grouped) begin
                abs_idx = rec_seq - 1 - k;
                gb += hist_bytes[p];
                gt += hist_req[p];
                if (abs_idx % reg_chunks == 0) begin
                    rsum += tput_recip(tput_kbps(gb, gt));
                    n++;
                    gb = 0;
                    gt = 0;
                end
            end else begin
                rsum += tput_recip(tput_kbps(hist_bytes[p], hist_req[p]));
                n++;
            end
        end
        if (n == 0 || rsum == 0)
            mean = 0;
        else begin
            mean = (64'(n) << 32) / rsum;
            if (mean > 64'hFFFF_FFFF)
                mean = 64'hFFFF_FFFF;
        end

        top = reg_top;
        cur = it.played;
        if (cur > top)
            cur = top;
        if (cur > 0 && 64'(ladder[cur]) > last)
            r = '{4'(cur - 1), DEC_DOWN, mean[31:0], last[31:0]};
        else if (cur < top && 64'(ladder[cur + 1]) < mean) begin
            if (64'(ladder[cur + 1]) > last)
                r = '{4'(cur), DEC_HOLD, mean[31:0], last[31:0]};
            else
                r = '{4'(cur + 1), DEC_UP, mean[31:0], last[31:0]};
        end else
            r = '{4'(cur), DEC_HOLD, mean[31:0], last[31:0]};
    endfunction

    function automatic dl_item_t ladder_load(input logic [3:0] s, input logic [31:0] v);
        dl_item_t it;
        it = '{CMD_LOAD, s, v, $urandom, $urandom, $urandom, 4'($urandom)};
        return it;
    endfunction

    function automatic dl_item_t dl_record(input logic [31:0] b, input logic [31:0] rq,
                                           input logic [31:0] xf, input logic [3:0] q);
        dl_item_t it;
        it = '{CMD_RECORD, 4'($urandom), $urandom, b, rq, xf, q};
        return it;
    endfunction

    // Append one transaction to the driver's queue.
    function automatic void add_item(input dl_item_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    // Random item: a record near the ladder rates, sometimes raw noise or a ladder load.
    function automatic dl_item_t random_item();
        int unsigned rate, us, sel;
        logic [31:0] xf;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return ladder_load(4'($urandom), (sel < 2) ? $urandom : $urandom_range(100, 16000));
        if (sel < 16)
            return dl_record(($urandom_range(0, 2) == 0) ? 32'd0 : $urandom,
                             ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom,
                             ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom, 4'($urandom));
        rate = $urandom_range(50, 17000);
        us   = $urandom_range(1000, 4000000);
        xf   = us - $urandom_range(0, us / 4);
        return dl_record(32'((64'(rate) * us) / 8000), us, xf, 4'($urandom));
    endfunction

    // Clock.
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Input driver: hold the transaction until taken, then idle for the drawn gap.
    always @(negedge clk) begin
        dl_item_t it;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && !in_taken)) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                it = pending_items.pop_front();
                command           <= it.cmd;
                ladder_slot       <= it.slot;
                ladder_kbps       <= it.kbps;
                bytes_received    <= it.bytes;
                request_to_end_us <= it.req_us;
                start_to_end_us   <= it.xfer_us;
                played_quality    <= it.played;
                in_valid          <= 1'b1;
                if ($urandom_range(0, 9) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 16);
            end else
                in_valid <= 1'b0;
        end
    end

    // Result receiver: draw a wait after each transaction; the long hold overrides.
    always @(negedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else begin
            if (out_taken)
                recv_wait = send_burst ? 0 : $urandom_range(0, 16);
            else if (recv_wait > 0)
                recv_wait = recv_wait - 1;
            out_ready <= !long_hold && recv_wait == 0;
        end
    end

    // Long back-pressure stretch once traffic is steady, so the core fills up.
    initial begin
        long_hold = 1'b0;
        while (picks_seen < 40)
            @(posedge clk);
        long_hold = 1'b1;
        repeat (15000) @(posedge clk);
        long_hold = 1'b0;
    end

    // Monitor: check results against the oldest prediction, predict on each accepted input.
    always @(posedge clk) begin
        pick_t exp_pick;
        pick_t new_pick;
        bit    got;
        in_taken  <= in_valid && in_ready;
        out_taken <= out_valid && out_ready;
        cfg_taken <= cfg_valid && cfg_ready;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                picks_seen++;
                if (pick_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: q=%0d dec=%0d mean=%0d last=%0d",
                                 next_quality, decision, mean_kbps, last_kbps);
                end else begin
                    exp_pick = pick_q.pop_front();
                    if (next_quality !== exp_pick.quality || decision !== exp_pick.dec ||
                        mean_kbps !== exp_pick.mean || last_kbps !== exp_pick.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     exp_pick.quality, exp_pick.dec, exp_pick.mean,
                                     exp_pick.last, next_quality, decision, mean_kbps,
                                     last_kbps);
                    end
                end
            end
            if (in_valid && in_ready) begin
                select_quality('{cmd_code_t'(command), ladder_slot, ladder_kbps,
                                 bytes_received, request_to_end_us, start_to_end_us,
                                 played_quality}, got, new_pick);
                if (got)
                    pick_q.insert(pick_q.size(), new_pick);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CHUNKS:  reg_chunks  = cfg_data[4:0];
                    CFG_CHUNKED: reg_chunked = cfg_data[0];
                    CFG_WINDOW:  reg_window  = cfg_data[5:0];
                    CFG_TOP:     reg_top     = cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    // Timeout watchdog.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Write one register; unused upper data bits carry noise the core must drop.
    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val, input logic [7:0] keep);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (val & keep) | (8'($urandom) & ~keep);
        do @(negedge clk); while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued item is sent and every pick has come back.
    task automatic drain();
        while (pending_items.size() != 0 || in_valid || pick_q.size() != 0)
            @(posedge clk);
        // A trailing ladder load has no result; let it settle.
        repeat (40) @(posedge clk);
    endtask

    task automatic set_regs(input int ch, input int cm, input int w, input int tq);
        write_reg(CFG_CHUNKS,  8'(ch), 8'h1F);
        write_reg(CFG_CHUNKED, 8'(cm), 8'h01);
        write_reg(CFG_WINDOW,  8'(w),  8'h3F);
        write_reg(CFG_TOP,     8'(tq), 8'h0F);
    endtask

    initial begin
        int ph;
        int i;
        int settings [6][4] = '{'{0, 0, 0, 15}, '{4, 1, 32, 15}, '{16, 1, 1, 7},
                                '{31, 1, 63, 3}, '{1, 1, 5, 15}, '{3, 0, 8, 0}};
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        command = 1'b0;
        ladder_slot = '0;
        ladder_kbps = '0;
        bytes_received = '0;
        request_to_end_us = '0;
        start_to_end_us = '0;
        played_quality = '0;
        mismatches = 0;
        picks_seen = 0;
        send_gap = 0;
        recv_wait = 0;
        send_burst = 1'b0;
        cycles = 0;
        hist_wpos = '0;
        rec_total = 0;
        rec_seq = 0;
        reg_chunks = '0;
        reg_chunked = 1'b0;
        reg_window = 6'd20;
        reg_top = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed: fill the whole ladder, zero and all-ones rates included.
        add_item(ladder_load(4'd0, 32'd0));
        for (i = 1; i < 15; i++)
            add_item(ladder_load(4'(i), 32'(i * 1000)));
        add_item(ladder_load(4'd15, 32'hFFFF_FFFF));
        drain();
        write_reg(CFG_TOP, 8'd15, 8'h0F);
        // Startup records, then zero times, empty records and saturation.
        add_item(dl_record(32'd0, 32'd0, 32'd0, 4'd0));
        add_item(dl_record(32'hFFFF_FFFF, 32'd0, 32'd0, 4'd15));
        add_item(dl_record(32'd1000, 32'd1000, 32'd500, 4'd3));
        add_item(dl_record(32'd500000, 32'd1000000, 32'd900000, 4'd4));
        add_item(dl_record(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 4'd15));
        add_item(dl_record(32'd0, 32'hFFFF_FFFF, 32'd7, 4'd0));
        add_item(dl_record(32'd1000000, 32'd2000000, 32'd0, 4'd2));
        add_item(dl_record(32'd1, 32'hFFFF_FFFF, 32'd1, 4'd8));
        drain();
        write_reg(CFG_TOP, 8'd9, 8'h0F);
        add_item(dl_record(32'd2000000, 32'd1000000, 32'd800000, 4'd15));
        add_item(ladder_load(4'd3, 32'd1));
        add_item(dl_record(32'd500, 32'd1000, 32'd900, 4'd9));
        drain();

        // Random phases, each under its own register setting.
        for (ph = 0; ph < 6; ph++) begin
            set_regs(settings[ph][0], settings[ph][1], settings[ph][2], settings[ph][3]);
            for (i = 0; i < 19; i++)
                add_item(random_item());
            drain();
        end

        if (mismatches == 0 && pick_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
